// File: hdl/srms_pkg.sv
package srms_pkg;

   // command codes carried in the request tuser
   localparam logic [1:0] CMD_GET  = 2'd0;
   localparam logic [1:0] CMD_SET  = 2'd1;
   localparam logic [1:0] CMD_ADD  = 2'd2;
   localparam logic [1:0] CMD_ZERO = 2'd3;

   // status codes carried in the response tuser
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   localparam int VAL_W = 64;
   localparam int COL_W = 8;

   localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   // sequencer states
   typedef enum logic [3:0] {
      CLEAR,
      IDLE,
      RD_A,
      RD_B,
      RD_C,
      SCAN_RD,
      SCAN_CMP,
      UPDATE,
      SHIFT_RD,
      SHIFT_WR,
      INSERT,
      OFS_RD,
      OFS_WR,
      ZERO,
      DONE
   } state_type;

endpackage

// File: hdl/sparse_row_matrix_store.sv
// Sequence: a get reads the row's two start offsets, scans the row for the column, then
// responds; a set or add that hits does the same, with its write in the update state; an
// insert moves the entries above the insert point up by one and bumps the start offsets of
// all later rows; zero clears every stored value; out-of-range requests skip the memories.
// Throughput: one request at a time, bounded by the single read port of the offset and
// entry memories. Reset: all ROWS+1 offset table entries are cleared, with req_tready low.
module sparse_row_matrix_store #(
   parameter int ROWS     = 256,
   parameter int CAPACITY = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // row[7:0], col[15:8], value[79:16]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // read_value[63:0]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int OW   = $clog2(CAPACITY + 1);
   localparam int IW   = $clog2(CAPACITY);
   localparam int RW   = $clog2(ROWS + 1);
   localparam int CMPW = (RW > 8) ? RW : 8;
   localparam int VW   = srms_pkg::VAL_W;
   localparam int CW   = srms_pkg::COL_W;

   srms_pkg::state_type state_ff, state_in;

   logic [1:0]    cmd_ff, cmd_in;
   logic [7:0]    row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [VW-1:0] val_ff, val_in;
   logic [OW-1:0] k_ff, k_in;
   logic [OW-1:0] end_ff, end_in;
   logic [OW-1:0] at_ff, at_in;
   logic [OW-1:0] count_ff, count_in;
   logic [RW-1:0] q_ff, q_in;
   logic [VW-1:0] old_ff, old_in;
   logic [VW-1:0] res_ff, res_in;
   logic [1:0]    st_ff, st_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]    rsp_user_ff, rsp_user_in;

   // memory ports
   logic          ofs_we;
   logic [RW-1:0] ofs_waddr, ofs_raddr;
   logic [OW-1:0] ofs_wdata, ofs_rdata;
   logic          col_we, val_we;
   logic [IW-1:0] ent_waddr, ent_raddr;
   logic [CW-1:0] ent_wcol, ent_rcol;
   logic [VW-1:0] ent_wval, ent_rval;

   logic [VW-1:0] add_sum;
   logic          add_sat;
   logic [OW-1:0] k_dec;
   logic          req_fire;
   logic          in_range;
   logic          rsp_load;

   // row start offsets
   srms_ram #(.DEPTH(ROWS + 1), .ADDR_W(RW), .WIDTH(OW)) u_ofs (
      .clock   (clock),
      .wr_en   (ofs_we),
      .wr_addr (ofs_waddr),
      .wr_data (ofs_wdata),
      .rd_addr (ofs_raddr),
      .rd_data (ofs_rdata)
   );

   // column indexes
   srms_ram #(.DEPTH(CAPACITY), .ADDR_W(IW), .WIDTH(CW)) u_col (
      .clock   (clock),
      .wr_en   (col_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wcol),
      .rd_addr (ent_raddr),
      .rd_data (ent_rcol)
   );

   // entry values
   srms_ram #(.DEPTH(CAPACITY), .ADDR_W(IW), .WIDTH(VW)) u_val (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wval),
      .rd_addr (ent_raddr),
      .rd_data (ent_rval)
   );

   // accumulate unit
   srms_sat_add u_add (
      .a   (old_ff),
      .b   (val_ff),
      .sum (add_sum),
      .sat (add_sat)
   );

   assign req_tready = (state_ff == srms_pkg::IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign in_range   = (CMPW'(req_tdata[7:0]) < CMPW'(ROWS)) &&
                       (CMPW'(req_tdata[15:8]) < CMPW'(ROWS));
   assign k_dec      = k_ff - OW'(1);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srms_pkg::CLEAR;
         count_ff     <= '0;
         q_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         q_ff         <= q_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and work registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      val_ff      <= val_in;
      k_ff        <= k_in;
      end_ff      <= end_in;
      at_ff       <= at_in;
      old_ff      <= old_in;
      res_ff      <= res_in;
      st_ff       <= st_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      val_in    = val_ff;
      k_in      = k_ff;
      end_in    = end_ff;
      at_in     = at_ff;
      count_in  = count_ff;
      q_in      = q_ff;
      old_in    = old_ff;
      res_in    = res_ff;
      st_in     = st_ff;
      rsp_load  = 1'b0;

      ofs_we    = 1'b0;
      ofs_waddr = q_ff;
      ofs_wdata = '0;
      ofs_raddr = q_ff;
      col_we    = 1'b0;
      val_we    = 1'b0;
      ent_waddr = k_ff[IW-1:0];
      ent_wcol  = col_ff;
      ent_wval  = val_ff;
      ent_raddr = k_ff[IW-1:0];

      case (state_ff)
         // sweep the offset table to zero after reset
         srms_pkg::CLEAR: begin
            ofs_we = 1'b1;
            if (q_ff == RW'(ROWS)) begin
               state_in = srms_pkg::IDLE;
            end else begin
               q_in = q_ff + RW'(1);
            end
         end

         srms_pkg::IDLE: begin
            if (req_fire) begin
               cmd_in = req_tuser;
               row_in = req_tdata[7:0];
               col_in = req_tdata[15:8];
               val_in = req_tdata[79:16];
               res_in = '0;
               st_in  = srms_pkg::ST_OK;
               if (req_tuser == srms_pkg::CMD_ZERO) begin
                  k_in = '0;
                  state_in = (count_ff == '0) ? srms_pkg::DONE : srms_pkg::ZERO;
               end else if (!in_range) begin
                  state_in = srms_pkg::DONE;
               end else begin
                  state_in = srms_pkg::RD_A;
               end
            end
         end

         // fetch row_start[row] and row_start[row+1]
         srms_pkg::RD_A: begin
            ofs_raddr = RW'(row_ff);
            state_in  = srms_pkg::RD_B;
         end

         srms_pkg::RD_B: begin
            ofs_raddr = RW'(row_ff) + RW'(1);
            k_in      = ofs_rdata;
            at_in     = (ofs_rdata > count_ff) ? count_ff : ofs_rdata;
            state_in  = srms_pkg::RD_C;
         end

         srms_pkg::RD_C: begin
            end_in   = ofs_rdata;
            state_in = srms_pkg::SCAN_RD;
         end

         // walk the row looking for the column
         srms_pkg::SCAN_RD: begin
            if (k_ff >= end_ff) begin
               if (cmd_ff == srms_pkg::CMD_GET) begin
                  state_in = srms_pkg::DONE;
               end else if (count_ff == OW'(CAPACITY)) begin
                  st_in    = srms_pkg::ST_FULL;
                  state_in = srms_pkg::DONE;
               end else begin
                  // absent: old value is zero, so the new value is the operand
                  k_in     = count_ff;
                  state_in = srms_pkg::SHIFT_RD;
               end
            end else begin
               state_in = srms_pkg::SCAN_CMP;
            end
         end

         srms_pkg::SCAN_CMP: begin
            if (ent_rcol == col_ff) begin
               old_in   = ent_rval;
               state_in = srms_pkg::UPDATE;
            end else begin
               k_in     = k_ff + OW'(1);
               state_in = srms_pkg::SCAN_RD;
            end
         end

         // element present
         srms_pkg::UPDATE: begin
            case (cmd_ff)
               srms_pkg::CMD_SET: begin
                  val_we = 1'b1;
                  res_in = val_ff;
               end
               srms_pkg::CMD_ADD: begin
                  val_we   = 1'b1;
                  ent_wval = add_sum;
                  res_in   = add_sum;
                  st_in    = add_sat ? srms_pkg::ST_SAT : srms_pkg::ST_OK;
               end
               default: begin
                  res_in = old_ff;
               end
            endcase
            state_in = srms_pkg::DONE;
         end

         // move entries above the insert point up by one, top first
         srms_pkg::SHIFT_RD: begin
            ent_raddr = k_dec[IW-1:0];
            if (k_ff == at_ff) begin
               state_in = srms_pkg::INSERT;
            end else begin
               state_in = srms_pkg::SHIFT_WR;
            end
         end

         srms_pkg::SHIFT_WR: begin
            col_we   = 1'b1;
            val_we   = 1'b1;
            ent_wcol = ent_rcol;
            ent_wval = ent_rval;
            k_in     = k_dec;
            state_in = srms_pkg::SHIFT_RD;
         end

         srms_pkg::INSERT: begin
            col_we    = 1'b1;
            val_we    = 1'b1;
            ent_waddr = at_ff[IW-1:0];
            count_in  = count_ff + OW'(1);
            res_in    = val_ff;
            q_in      = RW'(row_ff) + RW'(1);
            state_in  = srms_pkg::OFS_RD;
         end

         // bump the start offsets of all later rows
         srms_pkg::OFS_RD: begin
            state_in = srms_pkg::OFS_WR;
         end

         srms_pkg::OFS_WR: begin
            ofs_we    = 1'b1;
            ofs_wdata = ofs_rdata + OW'(1);
            if (q_ff == RW'(ROWS)) begin
               state_in = srms_pkg::DONE;
            end else begin
               q_in     = q_ff + RW'(1);
               state_in = srms_pkg::OFS_RD;
            end
         end

         // clear every stored value
         srms_pkg::ZERO: begin
            val_we   = 1'b1;
            ent_wval = '0;
            if (k_ff + OW'(1) == count_ff) begin
               state_in = srms_pkg::DONE;
            end else begin
               k_in = k_ff + OW'(1);
            end
         end

         // hand the result to the output register once it is free
         srms_pkg::DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = srms_pkg::IDLE;
            end
         end

         default: begin
            state_in = srms_pkg::IDLE;
         end
      endcase

      // output register
      rsp_valid_in = (rsp_valid_ff && !rsp_tready) || rsp_load;
      rsp_data_in  = rsp_load ? res_ff : rsp_data_ff;
      rsp_user_in  = rsp_load ? st_ff : rsp_user_ff;
   end

   // entry count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= OW'(CAPACITY))
      else $error("entry count above capacity");

   // the shift walk never runs below the insert point
   a_shift_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srms_pkg::SHIFT_RD) |-> (k_ff >= at_ff))
      else $error("shift index below insert point");

   // the entry count only changes on an insert
   a_count_insert: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
         ($past(state_ff) == srms_pkg::INSERT))
      else $error("entry count changed outside an insert");

   // a refused insert always reports an absent element
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (st_ff == srms_pkg::ST_FULL)) |=> (rsp_tdata == '0))
      else $error("refused insert returned a value");

endmodule

// File: hdl/srms_ram.sv
// simple dual-port RAM, one write and one registered read per cycle
module srms_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int WIDTH  = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: hdl/srms_sat_add.sv
// signed Q32.32 adder with saturation to the extreme words
module srms_sat_add (
   input  logic [srms_pkg::VAL_W-1:0] a,
   input  logic [srms_pkg::VAL_W-1:0] b,
   output logic [srms_pkg::VAL_W-1:0] sum,
   output logic                       sat
);

   localparam int MSB = srms_pkg::VAL_W - 1;

   logic [srms_pkg::VAL_W-1:0] raw;

   always_comb begin
      raw = a + b;
      // overflow: operands agree in sign, result does not
      sat = (a[MSB] == b[MSB]) && (raw[MSB] != a[MSB]);
      if (sat) begin
         sum = a[MSB] ? srms_pkg::VAL_MIN : srms_pkg::VAL_MAX;
      end else begin
         sum = raw;
      end
   end

endmodule

// File: tb/tb_sparse_row_matrix_store.sv
`timescale 1ns / 1ps

module tb_sparse_row_matrix_store;

   localparam int ROWS         = 256;
   localparam int CAPACITY     = 4096;
   localparam int RANDOM_ITEMS = 460;
   localparam int LONG_STALL   = 300;
   localparam int IDLE_LIMIT   = 40000;
   localparam int PRINT_CAP    = 60;

   typedef struct packed {
      logic [63:0] read_value;
      logic [1:0]  status;
   } elem_result_type;

   typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata  = '0;                  // row[7:0], col[15:8], value[79:16]
   logic [1:0]  req_tuser  = srms_pkg::CMD_GET;   // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;                        // read_value[63:0]
   logic [1:0]  rsp_tuser;                        // status[1:0]

   // shadow of the matrix keyed by {row, col}, and results still to come
   logic [63:0]     shadow_elem [logic [15:0]];
   int              shadow_count = 0;
   elem_result_type elem_results_due [$];

   int mismatch_count = 0;
   int idle_cycles    = 0;

   // sender pacing
   int burst_left = 0;
   bit gaps_on    = 1'b1;

   // receiver pacing
   int             long_stalls_asked = 0;
   int             long_stalls_done  = 0;
   int             hold_left         = 0;
   int             pattern_left      = 0;
   int             phase             = 0;
   ready_mode_type ready_mode        = RDY_ALWAYS;

   sparse_row_matrix_store #(
      .ROWS     (ROWS),
      .CAPACITY (CAPACITY)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t: %s: got %h, want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // apply one request to the shadow matrix and return the response it causes
   function automatic elem_result_type apply_matrix_op(input logic [1:0] cmd,
         input logic [7:0] row, input logic [7:0] col, input logic [63:0] val);
      elem_result_type res;
      logic [15:0]     key;
      logic [63:0]     old_val;
      logic [63:0]     sum;
      bit              present;
      res.read_value = '0;
      res.status     = srms_pkg::ST_OK;
      key     = {row, col};
      present = shadow_elem.exists(key);
      old_val = present ? shadow_elem[key] : '0;
      if (cmd == srms_pkg::CMD_ZERO) begin
         // values cleared, structure kept
         foreach (shadow_elem[k])
            shadow_elem[k] = '0;
      end else if (int'(row) < ROWS && int'(col) < ROWS) begin
         if (cmd == srms_pkg::CMD_GET) begin
            res.read_value = old_val;
         end else begin
            sum = val;
            if (cmd == srms_pkg::CMD_ADD) begin
               sum = old_val + val;
               // same-sign operands with a sign flip in the sum: clamp
               if (old_val[63] == val[63] && sum[63] != old_val[63]) begin
                  sum        = old_val[63] ? srms_pkg::VAL_MIN : srms_pkg::VAL_MAX;
                  res.status = srms_pkg::ST_SAT;
               end
            end
            if (!present && shadow_count >= CAPACITY) begin
               res.status = srms_pkg::ST_FULL;
            end else begin
               if (!present)
                  shadow_count++;
               shadow_elem[key] = sum;
               res.read_value   = sum;
            end
         end
      end
      return res;
   endfunction

   // mostly extremes and small magnitudes, some full-width random words
   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return srms_pkg::VAL_MAX;
         1:       return srms_pkg::VAL_MIN;
         2:       return '0;
         3:       return {64{1'b1}};
         4:       return {(($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : 32'h0),
                          32'($urandom)};
         5:       return srms_pkg::VAL_MAX - 64'($urandom_range(0, 255));
         6:       return srms_pkg::VAL_MIN + 64'($urandom_range(0, 255));
         default: return {32'($urandom), 32'($urandom)};
      endcase
   endfunction

   // send one request; entered and left at a falling edge
   task automatic send_request(input logic [1:0] cmd, input logic [7:0] row,
                               input logic [7:0] col, input logic [63:0] val);
      int gap;
      if (burst_left == 0) begin
         gap        = gaps_on ? $urandom_range(0, 6) : 0;
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {val, col, row};
      req_tuser  <= cmd;
      do @(posedge clock); while (req_tready !== 1'b1);
      elem_results_due.push_back(apply_matrix_op(cmd, row, col, val));
      @(negedge clock);
   endtask

   // response side: ready pattern is redrawn each time its random run length runs out;
   // a requested long hold-off overrides it
   always @(negedge clock) begin
      if (long_stalls_asked != long_stalls_done) begin
         long_stalls_done = long_stalls_asked;
         hold_left        = LONG_STALL;
      end
      if (pattern_left == 0) begin
         ready_mode   = ready_mode_type'($urandom_range(0, 3));
         pattern_left = $urandom_range(40, 300);
      end
      pattern_left--;
      phase++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (ready_mode)
            RDY_ALWAYS:  rsp_tready <= 1'b1;
            RDY_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
            RDY_SPARSE:  rsp_tready <= ($urandom_range(0, 3) == 0);
            default:     rsp_tready <= ((phase % 7) < 4);
         endcase
      end
   end

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      elem_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (elem_results_due.size() == 0) begin
            report_mismatch("response with no request due", rsp_tdata, '0);
         end else begin
            want = elem_results_due.pop_front();
            if (rsp_tdata !== want.read_value)
               report_mismatch("read_value", rsp_tdata, want.read_value);
            if (rsp_tuser !== want.status)
               report_mismatch("status", 64'(rsp_tuser), 64'(want.status));
         end
      end
   end

   // end the run if no request or response moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // field extremes, every command, saturation both ways, zero-value inserts
   task automatic test_directed_corners();
      send_request(srms_pkg::CMD_GET,  8'd0,   8'd0,   '0);                 // empty store
      send_request(srms_pkg::CMD_SET,  8'd0,   8'd0,   srms_pkg::VAL_MAX);
      send_request(srms_pkg::CMD_ADD,  8'd0,   8'd0,   64'd1);              // clamps high
      send_request(srms_pkg::CMD_SET,  8'd255, 8'd255, srms_pkg::VAL_MIN);
      send_request(srms_pkg::CMD_ADD,  8'd255, 8'd255, {64{1'b1}});         // clamps low
      send_request(srms_pkg::CMD_ADD,  8'd255, 8'd255, srms_pkg::VAL_MIN);
      send_request(srms_pkg::CMD_ADD,  8'd10,  8'd20,  '0);          // add of zero inserts
      send_request(srms_pkg::CMD_SET,  8'd10,  8'd21,  '0);          // set of zero inserts
      send_request(srms_pkg::CMD_GET,  8'd10,  8'd20,  srms_pkg::VAL_MAX); // value ignored
      send_request(srms_pkg::CMD_ADD,  8'd10,  8'd20,  srms_pkg::VAL_MIN);
      send_request(srms_pkg::CMD_ADD,  8'd10,  8'd20,  srms_pkg::VAL_MAX); // opposite signs
      send_request(srms_pkg::CMD_SET,  8'd0,   8'd255, 64'h0000_0001_8000_0000);
      send_request(srms_pkg::CMD_SET,  8'd255, 8'd0,   64'hAAAA_5555_0F0F_F0F0);
      send_request(srms_pkg::CMD_SET,  8'd0,   8'd0,   {64{1'b1}});         // overwrite
      send_request(srms_pkg::CMD_GET,  8'd0,   8'd255, '0);
      send_request(srms_pkg::CMD_GET,  8'd1,   8'd0,   '0);                 // absent row
      send_request(srms_pkg::CMD_ZERO, 8'hA5,  8'h5A,  64'h5555_AAAA_5555_AAAA);
      send_request(srms_pkg::CMD_GET,  8'd0,   8'd0,   '0);
      send_request(srms_pkg::CMD_GET,  8'd255, 8'd255, '0);
      send_request(srms_pkg::CMD_ADD,  8'd255, 8'd255, srms_pkg::VAL_MAX); // zeroed entry kept
      send_request(srms_pkg::CMD_SET,  8'd128, 8'd127, 64'h8000_0000_0000_0001);
      send_request(srms_pkg::CMD_GET,  8'd128, 8'd127, '0);
   endtask

   // mostly a small hot set of elements so gets and adds hit, some wide spread
   task automatic test_random_traffic(input int n_items);
      logic [1:0] cmd;
      logic [7:0] row;
      logic [7:0] col;
      int         pick;
      for (int i = 0; i < n_items; i++) begin
         if (i % 64 == 0)
            gaps_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         cmd  = (pick < 30) ? srms_pkg::CMD_GET : (pick < 58) ? srms_pkg::CMD_SET :
                (pick < 96) ? srms_pkg::CMD_ADD : srms_pkg::CMD_ZERO;
         if ($urandom_range(0, 9) == 0) begin
            row = 8'($urandom);
            col = 8'($urandom);
         end else begin
            row = 8'($urandom_range(0, 5));
            col = 8'($urandom_range(0, 7));
         end
         send_request(cmd, row, col, pick_value());
      end
      gaps_on = 1'b1;
   endtask

   // responses held off for a long stretch while requests keep coming
   task automatic test_back_pressure();
      gaps_on = 1'b0;
      long_stalls_asked++;
      for (int i = 0; i < 24; i++)
         send_request((i % 2 == 0) ? srms_pkg::CMD_ADD : srms_pkg::CMD_GET,
                      8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), pick_value());
      gaps_on = 1'b1;
   endtask

   // probe an absent element, insert it by an add, then clear all values
   task automatic test_absent_and_zero();
      logic [7:0] row;
      logic [7:0] col;
      do begin
         row = 8'($urandom);
         col = 8'($urandom);
      end while (shadow_elem.exists({row, col}));
      send_request(srms_pkg::CMD_GET, row, col, '0);                  // absent
      send_request(srms_pkg::CMD_ADD, row, col, 64'd5);               // add inserts
      send_request(srms_pkg::CMD_ADD, row, col, srms_pkg::VAL_MAX);   // clamps high
      send_request(srms_pkg::CMD_ZERO, 8'd0, 8'd0, '0);
      send_request(srms_pkg::CMD_GET, row, col, '0);
      test_random_traffic(40);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_random_traffic(RANDOM_ITEMS);
      test_back_pressure();
      test_absent_and_zero();
      req_tvalid <= 1'b0;
      // drain, then watch for stray responses
      while (elem_results_due.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
